// ===== sv/pfk_pkg.sv =====
// ----------------------------------------------------------------------------
// pfk_pkg: shared types, constants and helpers for the Playfair cipher core
// Letter indices, command descriptor between front and back, state codes and
// the small mod-5 helpers used for square coordinates.
// ----------------------------------------------------------------------------
package pfk_pkg;

    localparam int N_CELLS   = 25;
    localparam int N_LETTERS = 26;
    localparam int IDX_W     = 5;

    localparam logic [IDX_W-1:0] NUM_CELLS   = 5'd25;
    localparam logic [IDX_W-1:0] LAST_LETTER = 5'd25;
    localparam logic [IDX_W-1:0] IDX_I       = 5'd8;
    localparam logic [IDX_W-1:0] IDX_J       = 5'd9;

    localparam logic [7:0] CHAR_A     = 8'h41;
    localparam logic [7:0] CHAR_Z     = 8'h5A;
    localparam logic [7:0] CHAR_LOW_A = 8'h61;
    localparam logic [7:0] CHAR_LOW_Z = 8'h7A;
    localparam logic [7:0] CASE_GAP   = 8'h20;

    typedef enum logic [2:0] {
        MODE_CLEAR   = 3'd0,
        MODE_KEY     = 3'd1,
        MODE_FINISH  = 3'd2,
        MODE_ENCRYPT = 3'd3,
        MODE_DECRYPT = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        KIND_NOP,
        KIND_CLEAR,
        KIND_KEY,
        KIND_FINISH,
        KIND_PAIR
    } t_kind;

    typedef struct packed {
        t_kind            kind;
        logic             decrypt;
        logic             bad;
        logic [IDX_W-1:0] idx_a;
        logic [IDX_W-1:0] idx_b;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_POS,
        ST_CELL,
        ST_OUT
    } t_state;

    // Upper-case letter to index, J folded into I; top bit flags a valid letter.
    function automatic logic [IDX_W:0] letter_index(input logic [7:0] ch);
        logic [7:0]       off;
        logic [IDX_W-1:0] idx;
        off = ch - CHAR_A;
        idx = off[IDX_W-1:0];
        if (idx == IDX_J) begin
            idx = IDX_I;
        end
        return {(ch >= CHAR_A) && (ch <= CHAR_Z), idx};
    endfunction

    function automatic logic [2:0] row_of(input logic [IDX_W-1:0] p);
        logic [2:0] r;
        if (p >= 5'd20)      r = 3'd4;
        else if (p >= 5'd15) r = 3'd3;
        else if (p >= 5'd10) r = 3'd2;
        else if (p >= 5'd5)  r = 3'd1;
        else                 r = 3'd0;
        return r;
    endfunction

    function automatic logic [2:0] col_of(input logic [IDX_W-1:0] p);
        logic [2:0]       r;
        logic [IDX_W-1:0] base;
        r    = row_of(p);
        base = {r, 2'b00} + {2'b00, r};
        return 3'(p - base);
    endfunction

    // Advance one place round a row or column: +1 to encipher, +4 to decipher.
    function automatic logic [2:0] wrap5(input logic [2:0] v, input logic dec);
        logic [3:0] s;
        s = {1'b0, v} + (dec ? 4'd4 : 4'd1);
        if (s >= 4'd5) begin
            s = s - 4'd5;
        end
        return s[2:0];
    endfunction

    function automatic logic [IDX_W-1:0] cell_at(input logic [2:0] r, input logic [2:0] c);
        return {r, 2'b00} + {2'b00, r} + {2'b00, c};
    endfunction

endpackage

// ===== sv/pfk_channels.sv =====
// ----------------------------------------------------------------------------
// pfk channels: valid/ready interfaces for command and result transfers
// One interface for incoming commands, one for enciphered pairs.
// ----------------------------------------------------------------------------
interface pfk_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] mode;
    logic [7:0] key_byte;
    logic [7:0] letter_a;
    logic [7:0] letter_b;

    modport source (output valid, output mode, output key_byte, output letter_a,
                    output letter_b, input ready);
    modport sink   (input valid, input mode, input key_byte, input letter_a,
                    input letter_b, output ready);
endinterface

interface pfk_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_a;
    logic [7:0] out_b;
    logic       bad_letter;

    modport source (output valid, output out_a, output out_b, output bad_letter,
                    input ready);
    modport sink   (input valid, input out_a, input out_b, input bad_letter,
                    output ready);
endinterface

// ===== sv/playfair_key_square_cipher_core.sv =====
// ----------------------------------------------------------------------------
// playfair_key_square_cipher_core: 5x5 Playfair key square and pair cipher
// Builds the key square from key bytes, completes it on a finish command and
// enciphers or deciphers letter pairs against it.
// ----------------------------------------------------------------------------
//
//  channel  | dir | payload                          | transfer
//  ---------+-----+----------------------------------+------------------------
//  i_in     | in  | mode, key_byte, letter_a/b       | valid & ready
//  o_out    | out | out_a, out_b, bad_letter         | valid & ready
//
//  Clear and key byte commands are handled as they are dequeued; finish is
//  dequeued, then sweeps all 26 letters, one per cycle, through the position
//  and square RAMs.
//  A good pair goes through dequeue, position read, square read and result
//  load, set by the registered read ports of the two RAMs. A bad pair is answered as it is dequeued.
//  Synchronous active-low reset empties the square and the queue; RAM
//  contents are left as they are and only read once the square is complete.
//  A two-entry queue decouples intake from the back end, and the result
//  register frees the back end while a result waits on o_out.
//
module playfair_key_square_cipher_core
    import pfk_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    pfk_in_if.sink     i_in,
    pfk_out_if.source  o_out
);

    logic q_push;
    logic q_pop;
    logic q_full;
    logic q_empty;
    t_cmd front_cmd;
    t_cmd queue_cmd;

    // classify incoming transfers, drop items that cannot change anything
    pfk_front u_front (
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_cmd    (front_cmd)
    );

    // hold up to two classified commands while the back end is busy
    pfk_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_cmd   (queue_cmd)
    );

    // build the square and carry out pair lookups
    pfk_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_cmd     (queue_cmd),
        .o_pop     (q_pop),
        .o_out     (o_out)
    );

endmodule

// ===== sv/pfk_ram.sv =====
// ----------------------------------------------------------------------------
// pfk_ram: generic RAM, one write port, two registered read ports
// ----------------------------------------------------------------------------
module pfk_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end

endmodule

// ===== sv/pfk_front.sv =====
// ----------------------------------------------------------------------------
// pfk_front: command intake and classification
// Decodes the mode, folds key bytes to letter indices and checks pair letters.
// ----------------------------------------------------------------------------
module pfk_front
    import pfk_pkg::*;
(
    pfk_in_if.sink i_in,
    input  logic   i_q_full,
    output logic   o_push,
    output t_cmd   o_cmd
);

    logic [7:0]   key_up;
    logic [IDX_W:0] key_li;
    logic [IDX_W:0] pa_li;
    logic [IDX_W:0] pb_li;

    assign i_in.ready = !i_q_full;

    always_comb begin
        key_up = i_in.key_byte;
        if (i_in.key_byte >= CHAR_LOW_A && i_in.key_byte <= CHAR_LOW_Z) begin
            key_up = i_in.key_byte - CASE_GAP;
        end
        key_li = letter_index(key_up);
        pa_li  = letter_index(i_in.letter_a);
        pb_li  = letter_index(i_in.letter_b);

        o_cmd.kind    = KIND_NOP;
        o_cmd.decrypt = 1'b0;
        o_cmd.bad     = !pa_li[IDX_W] || !pb_li[IDX_W];
        o_cmd.idx_a   = pa_li[IDX_W-1:0];
        o_cmd.idx_b   = pb_li[IDX_W-1:0];

        unique case (i_in.mode)
            MODE_CLEAR:  o_cmd.kind = KIND_CLEAR;
            MODE_KEY: begin
                // drop non-letters here, they never reach the back end
                if (key_li[IDX_W]) begin
                    o_cmd.kind  = KIND_KEY;
                    o_cmd.idx_a = key_li[IDX_W-1:0];
                end
            end
            MODE_FINISH: o_cmd.kind = KIND_FINISH;
            MODE_ENCRYPT: o_cmd.kind = KIND_PAIR;
            MODE_DECRYPT: begin
                o_cmd.kind    = KIND_PAIR;
                o_cmd.decrypt = 1'b1;
            end
            default:     o_cmd.kind = KIND_NOP;
        endcase

        o_push = i_in.valid && !i_q_full && (o_cmd.kind != KIND_NOP);
    end

endmodule

// ===== sv/pfk_queue.sv =====
// ----------------------------------------------------------------------------
// pfk_queue: two-entry command queue between front and back
// ----------------------------------------------------------------------------
module pfk_queue
    import pfk_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_cmd
);

    t_cmd       r_mem [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_level;
    logic       do_pop;

    assign o_full  = (r_level == 2'd2);
    assign o_empty = (r_level == 2'd0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_level  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_level <= r_level + {1'b0, i_push} - {1'b0, do_pop};
        end
    end

endmodule

// ===== sv/pfk_back.sv =====
// ----------------------------------------------------------------------------
// pfk_back: key square builder and pair cipher engine
// Holds the square and letter positions in RAM, runs the fill sweep and the
// three-step pair lookup, and drives the result register.
// ----------------------------------------------------------------------------
module pfk_back
    import pfk_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_empty,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    pfk_out_if.source  o_out
);

    t_state                 r_state, n_state;
    t_cmd                   r_cmd, n_cmd;
    logic [IDX_W-1:0]       r_fill_idx, n_fill_idx;
    logic [N_LETTERS-1:0]   r_seen, n_seen;
    logic [IDX_W-1:0]       r_count, n_count;
    logic                   r_ready, n_ready;
    logic [IDX_W-1:0]       r_cell_a, n_cell_a;
    logic [IDX_W-1:0]       r_cell_b, n_cell_b;
    logic                   r_out_valid, n_out_valid;
    logic [7:0]             r_out_a, n_out_a;
    logic [7:0]             r_out_b, n_out_b;
    logic                   r_out_bad, n_out_bad;

    logic                   out_free;
    logic                   app_req;
    logic [IDX_W-1:0]       app_idx;
    logic                   app_do;
    logic [IDX_W-1:0]       pos_rd_a, pos_rd_b;
    logic [IDX_W-1:0]       sq_rd_a, sq_rd_b;
    logic [IDX_W-1:0]       sq_raddr_a, sq_raddr_b;
    logic [2:0]             ra, ca, rb, cb;

    assign out_free = !r_out_valid || o_out.ready;
    assign app_do   = app_req && !r_seen[app_idx] && (r_count < NUM_CELLS);

    pfk_ram #(.WIDTH(IDX_W), .DEPTH(N_CELLS)) u_square (
        .i_clk     (i_clk),
        .i_we      (app_do),
        .i_waddr   (r_count),
        .i_wdata   (app_idx),
        .i_raddr_a (sq_raddr_a),
        .i_raddr_b (sq_raddr_b),
        .o_rdata_a (sq_rd_a),
        .o_rdata_b (sq_rd_b)
    );

    pfk_ram #(.WIDTH(IDX_W), .DEPTH(N_LETTERS)) u_position (
        .i_clk     (i_clk),
        .i_we      (app_do),
        .i_waddr   (app_idx),
        .i_wdata   (r_count),
        .i_raddr_a (r_cmd.idx_a),
        .i_raddr_b (r_cmd.idx_b),
        .o_rdata_a (pos_rd_a),
        .o_rdata_b (pos_rd_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_seen      <= '0;
            r_count     <= '0;
            r_ready     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_seen      <= n_seen;
            r_count     <= n_count;
            r_ready     <= n_ready;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_fill_idx <= n_fill_idx;
        r_cell_a   <= n_cell_a;
        r_cell_b   <= n_cell_b;
        r_out_a    <= n_out_a;
        r_out_b    <= n_out_b;
        r_out_bad  <= n_out_bad;
    end

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_fill_idx  = r_fill_idx;
        n_seen      = r_seen;
        n_count     = r_count;
        n_ready     = r_ready;
        n_cell_a    = r_cell_a;
        n_cell_b    = r_cell_b;
        n_out_valid = r_out_valid && !o_out.ready;
        n_out_a     = r_out_a;
        n_out_b     = r_out_b;
        n_out_bad   = r_out_bad;
        o_pop       = 1'b0;
        app_req     = 1'b0;
        app_idx     = i_cmd.idx_a;
        sq_raddr_a  = r_cell_a;
        sq_raddr_b  = r_cell_b;

        ra = row_of(pos_rd_a);
        ca = col_of(pos_rd_a);
        rb = row_of(pos_rd_b);
        cb = col_of(pos_rd_b);

        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    unique case (i_cmd.kind)
                        KIND_CLEAR: begin
                            o_pop   = 1'b1;
                            n_seen  = '0;
                            n_count = '0;
                            n_ready = 1'b0;
                        end
                        KIND_KEY: begin
                            o_pop   = 1'b1;
                            app_req = !r_ready;
                        end
                        KIND_FINISH: begin
                            o_pop = 1'b1;
                            if (!r_ready) begin
                                n_fill_idx = '0;
                                n_state    = ST_FILL;
                            end
                        end
                        KIND_PAIR: begin
                            if (i_cmd.bad || !r_ready) begin
                                if (out_free) begin
                                    o_pop       = 1'b1;
                                    n_out_valid = 1'b1;
                                    n_out_a     = '0;
                                    n_out_b     = '0;
                                    n_out_bad   = 1'b1;
                                end
                            end else begin
                                o_pop   = 1'b1;
                                n_cmd   = i_cmd;
                                n_state = ST_POS;
                            end
                        end
                        default: o_pop = 1'b1;
                    endcase
                    if (app_do) begin
                        n_seen[app_idx] = 1'b1;
                        n_count         = r_count + 5'd1;
                    end
                end
            end
            ST_FILL: begin
                // one letter a cycle, skip J, append only unseen letters
                app_req    = (r_fill_idx != IDX_J);
                app_idx    = r_fill_idx;
                n_fill_idx = r_fill_idx + 5'd1;
                if (app_do) begin
                    n_seen[app_idx] = 1'b1;
                    n_count         = r_count + 5'd1;
                end
                if (r_fill_idx == LAST_LETTER) begin
                    n_ready = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            ST_POS: begin
                n_state = ST_CELL;
            end
            ST_CELL: begin
                if (ra == rb) begin
                    n_cell_a = cell_at(ra, wrap5(ca, r_cmd.decrypt));
                    n_cell_b = cell_at(rb, wrap5(cb, r_cmd.decrypt));
                end else if (ca == cb) begin
                    n_cell_a = cell_at(wrap5(ra, r_cmd.decrypt), ca);
                    n_cell_b = cell_at(wrap5(rb, r_cmd.decrypt), cb);
                end else begin
                    n_cell_a = cell_at(ra, cb);
                    n_cell_b = cell_at(rb, ca);
                end
                sq_raddr_a = n_cell_a;
                sq_raddr_b = n_cell_b;
                n_state    = ST_OUT;
            end
            ST_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_a     = CHAR_A + {3'b000, sq_rd_a};
                    n_out_b     = CHAR_A + {3'b000, sq_rd_b};
                    n_out_bad   = 1'b0;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.out_a      = r_out_a;
    assign o_out.out_b      = r_out_b;
    assign o_out.bad_letter = r_out_bad;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= NUM_CELLS)
        else $error("fill count beyond square size");

    a_seen_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_seen) == int'(r_count))
        else $error("seen letters disagree with fill count");

    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ready) |-> r_count == NUM_CELLS)
        else $error("square marked ready while incomplete");

    a_pair_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) && out_free |=> r_out_valid && !r_out_bad)
        else $error("pair lookup finished without a good result");
`endif

endmodule
